### design/vertex_transform_to_screen_defines.svh
`ifndef VERTEX_TRANSFORM_TO_SCREEN_DEFINES_SVH
`define VERTEX_TRANSFORM_TO_SCREEN_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define VTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define VTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/vts_pkg.sv
package vts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int VP_W          = 13;
    localparam int MAT_IDX_W     = 4;
    localparam int MAT_DEPTH     = 16;
    localparam int CLIP_IDX_W    = 2;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int PC_W          = 5;
    localparam int DIV_CNT_W     = 5;
    localparam int ACC_W         = 66;
    localparam int PROD_W        = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = 8'd1;
    localparam logic [VP_W-1:0]      VP_WIDTH_RST  = 13'd800;
    localparam logic [VP_W-1:0]      VP_HEIGHT_RST = 13'd600;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_XFORM = 1'b1;

    localparam logic [CLIP_IDX_W-1:0] CLIP_X_IDX = 2'd0;
    localparam logic [CLIP_IDX_W-1:0] CLIP_Y_IDX = 2'd1;
    localparam logic [CLIP_IDX_W-1:0] CLIP_Z_IDX = 2'd2;
    localparam logic [CLIP_IDX_W-1:0] CLIP_W_IDX = 2'd3;

    localparam logic [PC_W-1:0]      SCREEN_STEP = 5'd26;
    localparam logic [PC_W-1:0]      LAST_STEP   = 5'd28;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 5'd31;

    localparam logic signed [COORD_W-1:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] I32_MIN = 32'sh8000_0000;

    typedef enum logic {
        OPA_MAT,
        OPA_CLIP
    } opa_t;

    typedef enum logic [2:0] {
        OPB_VX,
        OPB_VY,
        OPB_VZ,
        OPB_ONE,
        OPB_VPW,
        OPB_VPH
    } opb_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLIP_ACC,
        WR_CLIP_DIV,
        WR_SX
    } wr_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_DIV,
        HOLD_OUT
    } hold_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_W_NOT_POS,
        JMP_END
    } jump_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic [MAT_IDX_W-1:0]  addr;
        opa_t                  opa;
        opb_t                  opb;
        acc_t                  acc;
        wr_t                   wr;
        logic [CLIP_IDX_W-1:0] dst;
        logic                  div_start;
        logic [CLIP_IDX_W-1:0] div_src;
        logic                  latch_flag;
        logic                  emit;
        hold_t                 hold;
        jump_t                 jump;
        logic [PC_W-1:0]       target;
    } uop_t;

    typedef struct packed {
        uop_t uop;
        logic act;
    } vts_ctrl_t;

    typedef struct packed {
        logic w_not_pos;
        logic div_busy;
        logic out_blocked;
    } vts_status_t;

    localparam uop_t UOP_NOP = '{
        addr:       '0,
        opa:        OPA_MAT,
        opb:        OPB_VX,
        acc:        ACC_HOLD,
        wr:         WR_NONE,
        dst:        '0,
        div_start:  1'b0,
        div_src:    '0,
        latch_flag: 1'b0,
        emit:       1'b0,
        hold:       HOLD_NONE,
        jump:       JMP_NEXT,
        target:     '0
    };

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > ACC_W'(I32_MAX)) begin
            r = I32_MAX;
        end
        else if (v < ACC_W'(I32_MIN)) begin
            r = I32_MIN;
        end
        else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic uop_t uop_mac(input logic [MAT_IDX_W-1:0] addr, input opb_t opb,
                                     input acc_t acc, input wr_t wr,
                                     input logic [CLIP_IDX_W-1:0] dst);
        uop_t u;
        u      = UOP_NOP;
        u.addr = addr;
        u.opb  = opb;
        u.acc  = acc;
        u.wr   = wr;
        u.dst  = dst;
        return u;
    endfunction

    // Microprogram: sixteen pipelined multiply-accumulates, w test, three
    // divides on the shared divider, screen map, then hand over the result.
    function automatic uop_t vts_ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        u = UOP_NOP;
        unique case (pc)
            5'd0:  u = uop_mac(4'd0,  OPB_VX,  ACC_HOLD, WR_NONE,     CLIP_X_IDX);
            5'd1:  u = uop_mac(4'd1,  OPB_VY,  ACC_LOAD, WR_NONE,     CLIP_X_IDX);
            5'd2:  u = uop_mac(4'd2,  OPB_VZ,  ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd3:  u = uop_mac(4'd3,  OPB_ONE, ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd4:  u = uop_mac(4'd4,  OPB_VX,  ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd5:  u = uop_mac(4'd5,  OPB_VY,  ACC_LOAD, WR_CLIP_ACC, CLIP_X_IDX);
            5'd6:  u = uop_mac(4'd6,  OPB_VZ,  ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd7:  u = uop_mac(4'd7,  OPB_ONE, ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd8:  u = uop_mac(4'd8,  OPB_VX,  ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd9:  u = uop_mac(4'd9,  OPB_VY,  ACC_LOAD, WR_CLIP_ACC, CLIP_Y_IDX);
            5'd10: u = uop_mac(4'd10, OPB_VZ,  ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd11: u = uop_mac(4'd11, OPB_ONE, ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd12: u = uop_mac(4'd12, OPB_VX,  ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd13: u = uop_mac(4'd13, OPB_VY,  ACC_LOAD, WR_CLIP_ACC, CLIP_Z_IDX);
            5'd14: u = uop_mac(4'd14, OPB_VZ,  ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd15: u = uop_mac(4'd15, OPB_ONE, ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd16: u = uop_mac(4'd0,  OPB_VX,  ACC_ADD,  WR_NONE,     CLIP_X_IDX);
            5'd17: u = uop_mac(4'd0,  OPB_VX,  ACC_HOLD, WR_CLIP_ACC, CLIP_W_IDX);
            5'd18: begin
                u.latch_flag = 1'b1;
                u.jump       = JMP_W_NOT_POS;
                u.target     = SCREEN_STEP;
            end
            5'd19: begin
                u.div_start = 1'b1;
                u.div_src   = CLIP_X_IDX;
            end
            5'd20: u.hold = HOLD_DIV;
            5'd21: begin
                u.wr        = WR_CLIP_DIV;
                u.dst       = CLIP_X_IDX;
                u.div_start = 1'b1;
                u.div_src   = CLIP_Y_IDX;
            end
            5'd22: u.hold = HOLD_DIV;
            5'd23: begin
                u.wr        = WR_CLIP_DIV;
                u.dst       = CLIP_Y_IDX;
                u.div_start = 1'b1;
                u.div_src   = CLIP_Z_IDX;
            end
            5'd24: u.hold = HOLD_DIV;
            5'd25: begin
                u.wr  = WR_CLIP_DIV;
                u.dst = CLIP_Z_IDX;
            end
            5'd26: begin
                u.opa  = OPA_CLIP;
                u.addr = MAT_IDX_W'(CLIP_X_IDX);
                u.opb  = OPB_VPW;
            end
            5'd27: begin
                u.opa  = OPA_CLIP;
                u.addr = MAT_IDX_W'(CLIP_Y_IDX);
                u.opb  = OPB_VPH;
                u.wr   = WR_SX;
            end
            5'd28: begin
                u.opa  = OPA_CLIP;
                u.addr = MAT_IDX_W'(CLIP_Y_IDX);
                u.opb  = OPB_VPH;
                u.emit = 1'b1;
                u.hold = HOLD_OUT;
                u.jump = JMP_END;
            end
            default: u.jump = JMP_END;
        endcase
        return u;
    endfunction

endpackage

### design/vts_in_if.sv
interface vts_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic [vts_pkg::MAT_IDX_W-1:0]          coeff_index;
    logic signed [vts_pkg::COORD_W-1:0]     coeff_value;
    logic signed [vts_pkg::COORD_W-1:0]     vert_x;
    logic signed [vts_pkg::COORD_W-1:0]     vert_y;
    logic signed [vts_pkg::COORD_W-1:0]     vert_z;

    modport source (
        output valid, action, coeff_index, coeff_value, vert_x, vert_y, vert_z,
        input  ready
    );

    modport sink (
        input  valid, action, coeff_index, coeff_value, vert_x, vert_y, vert_z,
        output ready
    );
endinterface

### design/vts_out_if.sv
interface vts_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [vts_pkg::COORD_W-1:0] screen_x;
    logic signed [vts_pkg::COORD_W-1:0] screen_y;
    logic signed [vts_pkg::COORD_W-1:0] depth;
    logic                               not_divided;

    modport source (
        output valid, screen_x, screen_y, depth, not_divided,
        input  ready
    );

    modport sink (
        input  valid, screen_x, screen_y, depth, not_divided,
        output ready
    );
endinterface

### design/vts_cfg_if.sv
interface vts_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vts_pkg::CFG_IDX_W-1:0]     index;
    logic [vts_pkg::CFG_DATA_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### design/vts_divider.sv
`include "vertex_transform_to_screen_defines.svh"

module vts_divider #(
    parameter int FRAC_BITS = vts_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [vts_pkg::COORD_W-1:0] numer,
    input  logic signed [vts_pkg::COORD_W-1:0] denom,
    output logic                               busy,
    output logic signed [vts_pkg::COORD_W-1:0] quot
);
    import vts_pkg::*;

    logic [COORD_W-1:0]   mag;
    logic [COORD_W-1:0]   hi;
    logic [COORD_W-1:0]   lo;
    logic                 ovf;
    logic [COORD_W:0]     trial;
    logic                 ge;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0]   quo_reg, quo_next;
    logic [COORD_W-1:0]   den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic                 ovf_reg, ovf_next;

    // Split (|numer| << FRAC_BITS) into the part above bit 31 and the rest.
    assign mag = numer[COORD_W-1] ? (~numer + 1'b1) : numer;
    assign hi  = mag >> (COORD_W - FRAC_BITS);
    assign lo  = mag << FRAC_BITS;
    assign ovf = (hi >= denom);

    assign trial = {rem_reg, quo_reg[COORD_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = hi;
            quo_next  = lo;
            den_next  = denom;
            neg_next  = numer[COORD_W-1];
            ovf_next  = ovf;
        end
        else if (busy_reg)
        begin
            // one restoring step: shift in the next bit, subtract if it fits
            rem_next = ge ? COORD_W'(trial - {1'b0, den_reg}) : trial[COORD_W-1:0];
            quo_next = {quo_reg[COORD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end

    // Apply the sign and saturate to 32 bit.
    always_comb
    begin
        if (ovf_reg)
        begin
            quot = neg_reg ? I32_MIN : I32_MAX;
        end
        else if (neg_reg)
        begin
            quot = (quo_reg > COORD_W'(I32_MIN)) ? I32_MIN : (~quo_reg + 1'b1);
        end
        else
        begin
            quot = quo_reg[COORD_W-1] ? I32_MAX : quo_reg;
        end
    end

    assign busy = busy_reg;

    `VTS_ASSERT_NXT(a_div_start_busy, start, busy_reg, "divider not busy after start")
    `VTS_ASSERT_NXT(a_div_finish, busy_reg && cnt_reg == DIV_LAST, !busy_reg, "divider overran")
    `VTS_ASSERT_IMP(a_div_idle_cnt, !busy_reg, cnt_reg == '0, "divider idle with count left")

endmodule

### design/vts_datapath.sv
module vts_datapath #(
    parameter int FRAC_BITS = vts_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vts_pkg::vts_ctrl_t                 ctrl,
    output vts_pkg::vts_status_t               status,
    input  logic                               accept,
    input  logic                               action,
    input  logic [vts_pkg::MAT_IDX_W-1:0]      coeff_index,
    input  logic signed [vts_pkg::COORD_W-1:0] coeff_value,
    input  logic signed [vts_pkg::COORD_W-1:0] vert_x,
    input  logic signed [vts_pkg::COORD_W-1:0] vert_y,
    input  logic signed [vts_pkg::COORD_W-1:0] vert_z,
    vts_out_if.source                          result,
    vts_cfg_if.sink                            cfg
);
    import vts_pkg::*;

    localparam logic signed [COORD_W-1:0] ONE = COORD_W'(64'd1 << FRAC_BITS);

    logic signed [COORD_W-1:0] m_reg [MAT_DEPTH];
    logic signed [COORD_W-1:0] c_reg [4];
    logic signed [COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [VP_W-1:0]           vpw_reg, vph_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [COORD_W-1:0] sx_reg;
    logic                      flag_reg;

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_sx_reg, out_sy_reg, out_z_reg;
    logic                      out_nd_reg;

    logic signed [COORD_W-1:0] opa, opb;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   offs_x, offs_y;
    logic signed [COORD_W-1:0] clip_acc, sx_val, sy_val;
    logic signed [COORD_W-1:0] div_quot;
    logic                      div_busy, div_go, emit_go, load_go;
    uop_t                      u;

    assign u       = ctrl.uop;
    assign div_go  = ctrl.act && u.div_start;
    assign emit_go = ctrl.act && u.emit;
    assign load_go = accept && (action == ACT_LOAD);

    // matrix store, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_DEPTH; i++)
            begin
                m_reg[i] <= (i[1:0] == i[3:2]) ? ONE : '0;
            end
        end
        else if (load_go)
        begin
            m_reg[coeff_index] <= coeff_value;
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpw_reg <= VP_WIDTH_RST;
            vph_reg <= VP_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_VP_WIDTH)
            begin
                vpw_reg <= cfg.data[VP_W-1:0];
            end
            if (cfg.index == CFG_VP_HEIGHT)
            begin
                vph_reg <= cfg.data[VP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_XFORM))
        begin
            vx_reg <= vert_x;
            vy_reg <= vert_y;
            vz_reg <= vert_z;
        end
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        unique case (u.opa)
            OPA_MAT:  opa = m_reg[u.addr];
            OPA_CLIP: opa = c_reg[u.addr[CLIP_IDX_W-1:0]];
            default:  opa = m_reg[u.addr];
        endcase
    end

    always_comb
    begin
        unique case (u.opb)
            OPB_VX:  opb = vx_reg;
            OPB_VY:  opb = vy_reg;
            OPB_VZ:  opb = vz_reg;
            OPB_ONE: opb = ONE;
            OPB_VPW: opb = $signed({{(COORD_W - VP_W){1'b0}}, vpw_reg});
            OPB_VPH: opb = $signed({{(COORD_W - VP_W){1'b0}}, vph_reg});
            default: opb = vx_reg;
        endcase
    end

    assign prod_next = opa * opb;
    assign prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.act)
        begin
            unique case (u.acc)
                ACC_LOAD: acc_next = prod_ext;
                ACC_ADD:  acc_next = acc_reg + prod_ext;
                default:  acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // exact sum scaled back with floor, then saturated
    assign clip_acc = sat32(acc_reg >>> FRAC_BITS);

    // screen map: product halved with floor, plus half the viewport as offset
    assign offs_x = $signed({{(ACC_W - VP_W){1'b0}}, vpw_reg}) <<< (FRAC_BITS - 1);
    assign offs_y = $signed({{(ACC_W - VP_W){1'b0}}, vph_reg}) <<< (FRAC_BITS - 1);
    assign sx_val = sat32((prod_ext >>> 1) + offs_x);
    assign sy_val = sat32(((-prod_ext) >>> 1) + offs_y);

    always_ff @(posedge clk)
    begin
        if (ctrl.act)
        begin
            unique case (u.wr)
                WR_CLIP_ACC: c_reg[u.dst] <= clip_acc;
                WR_CLIP_DIV: c_reg[u.dst] <= div_quot;
                WR_SX:       sx_reg <= sx_val;
                default:     ;
            endcase
            if (u.latch_flag)
            begin
                flag_reg <= status.w_not_pos;
            end
        end
    end

    vts_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .numer (c_reg[u.div_src]),
        .denom (c_reg[CLIP_W_IDX]),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // output register: holds a finished result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_sx_reg <= sx_reg;
            out_sy_reg <= sy_val;
            out_z_reg  <= c_reg[CLIP_Z_IDX];
            out_nd_reg <= flag_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.screen_x    = out_sx_reg;
    assign result.screen_y    = out_sy_reg;
    assign result.depth       = out_z_reg;
    assign result.not_divided = out_nd_reg;

    assign status.w_not_pos   = c_reg[CLIP_W_IDX][COORD_W-1] || (c_reg[CLIP_W_IDX] == '0);
    assign status.div_busy    = div_busy;
    assign status.out_blocked = out_valid_reg && !result.ready;

endmodule

### design/vts_sequencer.sv
`include "vertex_transform_to_screen_defines.svh"

module vts_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  vts_pkg::vts_status_t status,
    output vts_pkg::vts_ctrl_t   ctrl,
    output logic                 idle
);
    import vts_pkg::*;

    logic            run_reg, run_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uop_t            uop;
    logic            hold;

    assign uop = vts_ucode(pc_reg);

    // stall the step while the divider works or the result slot is taken
    assign hold = ((uop.hold == HOLD_DIV) && status.div_busy)
               || ((uop.hold == HOLD_OUT) && status.out_blocked);

    assign ctrl.uop = uop;
    assign ctrl.act = run_reg && !hold;
    assign idle     = !run_reg;

    always_comb
    begin
        run_next = run_reg;
        pc_next  = pc_reg;
        priority if (start)
        begin
            run_next = 1'b1;
            pc_next  = '0;
        end
        else if (ctrl.act)
        begin
            unique case (uop.jump)
                JMP_END:       run_next = 1'b0;
                JMP_W_NOT_POS: pc_next  = status.w_not_pos ? uop.target : pc_reg + 1'b1;
                default:       pc_next  = pc_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pc_reg  <= '0;
        end
        else
        begin
            run_reg <= run_next;
            pc_reg  <= pc_next;
        end
    end

    `VTS_ASSERT_IMP(a_seq_start_idle, start, !run_reg, "vertex taken while program runs")
    `VTS_ASSERT_NXT(a_seq_start_pc, start, run_reg && pc_reg == '0, "program did not begin")
    `VTS_ASSERT_IMP(a_seq_div_free, ctrl.act && uop.div_start, !status.div_busy, "divider reused")
    `VTS_ASSERT_IMP(a_seq_pc_range, run_reg, pc_reg <= LAST_STEP, "step counter past program")

endmodule

### design/vertex_transform_to_screen.sv
// Transform request: when clip w is not positive, 19 multiply-accumulate and test steps, then
// three screen-map steps; otherwise all 29 microcode steps, with holds while each of the three
// divides runs on the one divider. Load request: written to the matrix store on acceptance.
// A new request is taken the cycle after the program hands its result to the output register;
// that hand-over waits while the sink stalls, so one request is in work at a time.
// Reset: matrix to identity, viewport to 800 x 600, sequencer idle, no result pending.
module vertex_transform_to_screen #(
    parameter int FRAC_BITS = vts_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    vts_in_if.sink    vertex,
    vts_out_if.source result,
    vts_cfg_if.sink   cfg
);
    import vts_pkg::*;

    logic        idle;
    logic        accept;
    logic        start;
    vts_ctrl_t   ctrl;
    vts_status_t status;

    // Take a request only while no program is running; loads finish in the
    // same cycle, transforms start the microprogram.
    assign vertex.ready = idle;
    assign accept       = vertex.valid && vertex.ready;
    assign start        = accept && (vertex.action == ACT_XFORM);

    // Step counter and control store: one control word per step, with
    // holds on the divider and the output slot and a jump past the divides.
    vts_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .idle   (idle)
    );

    // Matrix store, shared multiplier and accumulator, clip registers,
    // divider, screen map and the output register.
    vts_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .accept      (accept),
        .action      (vertex.action),
        .coeff_index (vertex.coeff_index),
        .coeff_value (vertex.coeff_value),
        .vert_x      (vertex.vert_x),
        .vert_y      (vertex.vert_y),
        .vert_z      (vertex.vert_z),
        .result      (result),
        .cfg         (cfg)
    );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

// Vertex stage: checks matrix loads, clip transform, perspective divide and viewport map
// against an independent fixed-point predictor. The viewport is changed between phases.
module tb_top;
    import vts_pkg::*;

    localparam int FB          = FRAC_BITS_DEF;
    localparam int SETTLE      = 200;        // beyond the longest transform latency
    localparam int CYCLE_LIMIT = 1_500_000;  // several times the slowest legal run
    localparam int LONG_HOLD   = 400;        // receiver hold-off that backs up the input

    typedef logic signed [COORD_W-1:0] q16_t;

    localparam q16_t ONE_Q = 32'sd1 <<< FB;

    typedef struct packed {
        logic                 action;
        logic [MAT_IDX_W-1:0] coeff_index;
        q16_t                 coeff_value;
        q16_t                 vert_x;
        q16_t                 vert_y;
        q16_t                 vert_z;
    } vertex_req_t;

    typedef struct packed {
        q16_t screen_x;
        q16_t screen_y;
        q16_t depth;
        logic not_divided;
    } screen_pt_t;

    // Keeps a private copy of the matrix and viewport, works out the screen point of
    // every accepted transform request and checks the block's results in order.
    class screen_point_ledger;
        q16_t             coeff [MAT_DEPTH];
        logic [VP_W-1:0]  vp_width;
        logic [VP_W-1:0]  vp_height;
        screen_pt_t       pending_points [$];
        int               field_errors;

        function new();
            for (int i = 0; i < MAT_DEPTH; i++)
                coeff[i] = (i % 5 == 0) ? ONE_Q : '0;
            vp_width     = VP_WIDTH_RST;
            vp_height    = VP_HEIGHT_RST;
            field_errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_VP_WIDTH)
                vp_width = data[VP_W-1:0];
            else if (idx == CFG_VP_HEIGHT)
                vp_height = data[VP_W-1:0];
        endfunction

        function q16_t clamp32(logic signed [71:0] v);
            if (v > 72'(I32_MAX))
                return I32_MAX;
            if (v < 72'(I32_MIN))
                return I32_MIN;
            return v[COORD_W-1:0];
        endfunction

        // Exact four-term dot product, floored to the fixed-point grid.
        function q16_t clip_row(int row, q16_t vx, q16_t vy, q16_t vz);
            q16_t              operand [4];
            logic signed [71:0] acc;
            operand[0] = vx;
            operand[1] = vy;
            operand[2] = vz;
            operand[3] = ONE_Q;
            acc = '0;
            for (int c = 0; c < 4; c++)
                acc += 72'(coeff[row * 4 + c]) * 72'(operand[c]);
            return clamp32(acc >>> FB);
        endfunction

        // Quotient truncated toward zero.
        function q16_t divide_by_w(q16_t c, q16_t w);
            logic signed [71:0] num;
            logic signed [71:0] quo;
            num = 72'(c);
            if (num < 0)
                num = -num;
            num = num <<< FB;
            quo = num / 72'(w);
            if (c < 0)
                quo = -quo;
            return clamp32(quo);
        endfunction

        function screen_pt_t project_vertex(vertex_req_t r);
            q16_t               cx, cy, cz, cw;
            logic signed [71:0] w72, h72, sx, sy;
            screen_pt_t         pt;
            cx = clip_row(0, r.vert_x, r.vert_y, r.vert_z);
            cy = clip_row(1, r.vert_x, r.vert_y, r.vert_z);
            cz = clip_row(2, r.vert_x, r.vert_y, r.vert_z);
            cw = clip_row(3, r.vert_x, r.vert_y, r.vert_z);
            pt.not_divided = 1'b1;
            if (cw > 0)
            begin
                cx = divide_by_w(cx, cw);
                cy = divide_by_w(cy, cw);
                cz = divide_by_w(cz, cw);
                pt.not_divided = 1'b0;
            end
            w72 = $signed({59'd0, vp_width});
            h72 = $signed({59'd0, vp_height});
            sx  = ((72'(cx) * w72) >>> 1) + (w72 <<< (FB - 1));
            sy  = ((-72'(cy) * h72) >>> 1) + (h72 <<< (FB - 1));
            pt.screen_x = clamp32(sx);
            pt.screen_y = clamp32(sy);
            pt.depth    = cz;
            return pt;
        endfunction

        function void note_request(vertex_req_t r);
            if (r.action == ACT_LOAD)
                coeff[r.coeff_index] = r.coeff_value;
            else
                pending_points.push_back(project_vertex(r));
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                field_errors++;
                if (field_errors <= 10)
                    $display("mismatch on %s: expected %h, got %h", field, want, got);
            end
        endfunction

        function void check_result(screen_pt_t got);
            screen_pt_t want;
            if (pending_points.size() == 0)
            begin
                field_errors++;
                if (field_errors <= 10)
                    $display("result with nothing awaited: %h %h %h %b", got.screen_x,
                             got.screen_y, got.depth, got.not_divided);
                return;
            end
            want = pending_points.pop_front();
            compare_field("screen_x", want.screen_x, got.screen_x);
            compare_field("screen_y", want.screen_y, got.screen_y);
            compare_field("depth", want.depth, got.depth);
            compare_field("not_divided", 32'(want.not_divided), 32'(got.not_divided));
        endfunction

        function int outstanding();
            return pending_points.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    vts_in_if  vertex_ch ();
    vts_out_if result_ch ();
    vts_cfg_if cfg_ch ();

    screen_point_ledger ledger = new();

    // Idling controls shared by the sender, the receiver and the main sequence.
    int  in_gap_pct     = 0;
    int  out_stall_pct  = 0;
    int  rx_hold_cycles = 0;
    bit  quiet_tail     = 1'b0;
    int  cycle_count    = 0;

    vertex_transform_to_screen dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #10 clk = ~clk;

    // Watchdog: end the run if the traffic never drains.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check every accepted result, then decide ready for the next cycle.
    // A long hold-off requested by the main sequence is counted down here.
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                ledger.check_result('{result_ch.screen_x, result_ch.screen_y,
                                      result_ch.depth, result_ch.not_divided});
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct)
            begin
                // a random burst of stall, starting with this one
                stall_left = $urandom_range(0, 5);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Spread a value evenly over [-half, half].
    function automatic q16_t spread(int half);
        return q16_t'(int'($urandom_range(0, 2 * half)) - half);
    endfunction

    function automatic q16_t extreme_value();
        case ($urandom_range(0, 4))
            0: return I32_MAX;
            1: return I32_MIN;
            2: return '0;
            3: return -32'sd1;
            default: return ONE_Q;
        endcase
    endfunction

    // Mostly well-behaved coefficients, with some full-range and extreme ones.
    function automatic q16_t rand_coeff();
        case ($urandom_range(0, 8))
            0, 1, 2, 3, 4, 5: return spread(1 << 18);
            6: return spread(1 << 12);
            7: return q16_t'($urandom);
            default: return extreme_value();
        endcase
    endfunction

    function automatic q16_t rand_coord();
        case ($urandom_range(0, 8))
            0, 1, 2, 3, 4: return spread(1 << 26);
            5, 6: return spread(1 << 18);
            7: return q16_t'($urandom);
            default: return extreme_value();
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    // Unused fields carry random junk; the block must ignore them.
    function automatic vertex_req_t coeff_load(logic [MAT_IDX_W-1:0] idx, q16_t val);
        vertex_req_t r;
        r.action      = ACT_LOAD;
        r.coeff_index = idx;
        r.coeff_value = val;
        r.vert_x      = q16_t'($urandom);
        r.vert_y      = q16_t'($urandom);
        r.vert_z      = q16_t'($urandom);
        return r;
    endfunction

    function automatic vertex_req_t vertex_xform(q16_t x, q16_t y, q16_t z);
        vertex_req_t r;
        r.action      = ACT_XFORM;
        r.coeff_index = MAT_IDX_W'($urandom);
        r.coeff_value = q16_t'($urandom);
        r.vert_x      = x;
        r.vert_y      = y;
        r.vert_z      = z;
        return r;
    endfunction

    // Offer one request and hold it until accepted; valid stays high on return so that
    // back-to-back requests need no second assignment in one step.
    task automatic send(vertex_req_t r);
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct)
        begin
            vertex_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        vertex_ch.valid       <= 1'b1;
        vertex_ch.action      <= r.action;
        vertex_ch.coeff_index <= r.coeff_index;
        vertex_ch.coeff_value <= r.coeff_value;
        vertex_ch.vert_x      <= r.vert_x;
        vertex_ch.vert_y      <= r.vert_y;
        vertex_ch.vert_z      <= r.vert_z;
        do
            @(posedge clk);
        while (!vertex_ch.ready);
        ledger.note_request(r);
    endtask

    // Drop valid and wait for every awaited result, then for the given settle time.
    task automatic wait_drained(int settle);
        vertex_ch.valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        ledger.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Load a whole matrix: a perspective-style one (w follows -z or z, so both sides of
    // the divide test occur), a tame random one, or one with full-range entries.
    task automatic load_matrix();
        q16_t m [MAT_DEPTH];
        int   kind;
        kind = $urandom_range(0, 2);
        for (int i = 0; i < MAT_DEPTH; i++)
            m[i] = (kind == 0) ? '0 : (kind == 1) ? spread(1 << 18) : rand_coeff();
        if (kind == 0)
        begin
            m[0]  = q16_t'($urandom_range(1 << 14, 1 << 18));
            m[3]  = spread(1 << 20);
            m[5]  = q16_t'($urandom_range(1 << 14, 1 << 18));
            m[7]  = spread(1 << 20);
            m[10] = spread(1 << 17);
            m[11] = spread(1 << 20);
            m[14] = ($urandom_range(0, 3) == 0) ? ONE_Q : -ONE_Q;
            m[15] = spread(1 << 17);
        end
        for (int i = 0; i < MAT_DEPTH; i++)
            send(coeff_load(MAT_IDX_W'(i), m[i]));
    endtask

    // Random traffic: occasional whole matrices, a few single coefficient updates, and
    // mostly bursts of transforms. Idling odds change from stretch to stretch.
    task automatic run_random(int budget);
        int issued;
        int pick;
        int n;
        issued = 0;
        while (issued < budget)
        begin
            if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                in_gap_pct    = pick_idle_pct();
                out_stall_pct = pick_idle_pct();
            end
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                load_matrix();
                issued += MAT_DEPTH;
            end
            else if (pick <= 2)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send(coeff_load(MAT_IDX_W'($urandom_range(0, 15)), rand_coeff()));
                issued += n;
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) send(vertex_xform(rand_coord(), rand_coord(), rand_coord()));
                issued += n;
            end
        end
    endtask

    // Directed opening on the reset matrix and viewport.
    task automatic run_directed();
        // identity matrix at the coordinate extremes
        send(vertex_xform('0, '0, '0));
        send(vertex_xform(I32_MAX, I32_MAX, I32_MAX));
        send(vertex_xform(I32_MIN, I32_MIN, I32_MIN));
        // w of zero: no divide, flag raised
        send(coeff_load(4'd15, '0));
        send(vertex_xform(ONE_Q, -ONE_Q, I32_MIN));
        // negative w
        send(coeff_load(4'd15, -ONE_Q));
        send(vertex_xform(I32_MAX, I32_MIN, 32'sd5));
        // w of one step: the divide saturates
        send(coeff_load(4'd15, 32'sd1));
        send(vertex_xform(ONE_Q, -ONE_Q, 32'sd3 <<< FB));
        // extreme coefficients drive the multiply-accumulate into saturation
        send(coeff_load(4'd0, I32_MAX));
        send(coeff_load(4'd5, I32_MIN));
        send(coeff_load(4'd15, I32_MIN));
        send(vertex_xform(I32_MAX, I32_MIN, '0));
        send(coeff_load(4'd12, I32_MAX));
        send(coeff_load(4'd15, I32_MAX));
        send(vertex_xform(I32_MAX, I32_MAX, -32'sd1));
        // back to identity
        send(coeff_load(4'd0, ONE_Q));
        send(coeff_load(4'd5, ONE_Q));
        send(coeff_load(4'd12, '0));
        send(coeff_load(4'd15, ONE_Q));
        send(vertex_xform(-ONE_Q, ONE_Q, 32'sd1 <<< (FB - 1)));
    endtask

    initial
    begin
        // Initialise every input before the first edge and hold reset low before releasing it.
        rst_n                 <= 1'b0;
        vertex_ch.valid       <= 1'b0;
        vertex_ch.action      <= ACT_LOAD;
        vertex_ch.coeff_index <= '0;
        vertex_ch.coeff_value <= '0;
        vertex_ch.vert_x      <= '0;
        vertex_ch.vert_y      <= '0;
        vertex_ch.vert_z      <= '0;
        result_ch.ready       <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(300);

        // Smallest viewport; part way through, hold results back for a long stretch so
        // the block fills and stalls its input while requests keep coming.
        wait_drained(SETTLE);
        write_reg(CFG_VP_WIDTH, 32'd1);
        write_reg(CFG_VP_HEIGHT, 32'd1);
        run_random(150);
        rx_hold_cycles = LONG_HOLD;
        run_random(150);

        // Largest nominal viewport; writes beyond the two registers must change nothing.
        // Half way, pause the sender until every result is back.
        wait_drained(SETTLE);
        write_reg(CFG_VP_WIDTH, 32'd4096);
        write_reg(CFG_VP_HEIGHT, 32'd4096);
        write_reg(CFG_IDX_W'(2), $urandom);
        write_reg(CFG_IDX_W'(255), $urandom);
        run_random(150);
        wait_drained(0);
        run_random(150);

        // Zero viewport: scale and offset vanish.
        wait_drained(SETTLE);
        write_reg(CFG_VP_WIDTH, 32'd0);
        write_reg(CFG_VP_HEIGHT, 32'd0);
        run_random(300);

        // Above the nominal range, with upper data bits that the register drops.
        wait_drained(SETTLE);
        write_reg(CFG_VP_WIDTH, 32'hFFFF_FFFF);
        write_reg(CFG_VP_HEIGHT, 32'hFFFF_E000 | 32'd5000);
        run_random(300);

        // Final stretch at a random legal viewport with no idling on either side.
        wait_drained(SETTLE);
        write_reg(CFG_VP_WIDTH, $urandom_range(1, 4096));
        write_reg(CFG_VP_HEIGHT, $urandom_range(1, 4096));
        quiet_tail    = 1'b1;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        run_random(300);

        wait_drained(SETTLE);
        if (ledger.outstanding() != 0)
            $display("results still awaited: %0d", ledger.outstanding());
        if (ledger.field_errors == 0 && ledger.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
